/* hw/rtl/ssbs_pkg.sv */
// Shared types, constants and fixed-point helpers for the spline band setup block.
package ssbs_pkg;

    localparam int DATA_W         = 32;
    localparam int CNT_W          = 16;
    localparam int NDIM           = 3;
    localparam int IN_W           = 160;
    localparam int OUT_W          = 336;
    localparam int DIV_ITER       = 49;
    localparam int NUM_DIV_OPS    = 7;
    localparam int NUM_MUL_OPS    = 6;
    localparam int DEF_MAX_DIMS   = 3;
    localparam int DEF_MAX_POINTS = 65536;

    // One data point as it travels from the front to the back
    typedef struct packed {
        logic [DATA_W-1:0]           x;
        logic [DATA_W-1:0]           dy;
        logic [NDIM-1:0][DATA_W-1:0] y;
        logic                        fin;
        logic [CNT_W-1:0]            cnt;
    } t_point;

    // One band row, pending or complete
    typedef struct packed {
        logic                        valid;
        logic [CNT_W-1:0]            idx;
        logic [DATA_W-1:0]           w;
        logic [DATA_W-1:0]           lo;
        logic [DATA_W-1:0]           dg;
        logic [DATA_W-1:0]           up;
        logic [DATA_W-1:0]           gd;
        logic [DATA_W-1:0]           g1;
        logic [DATA_W-1:0]           g2;
        logic [NDIM-1:0][DATA_W-1:0] sd;
    } t_row;

    // Request to the shared divider
    typedef struct packed {
        logic              start;
        logic [DATA_W:0]   num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DELX,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROW,
        ST_MUL_A,
        ST_MUL_B,
        ST_BANDS,
        ST_EMIT,
        ST_UPDATE
    } t_bstate;

    // Sign-extend a 32-bit value to the 50-bit working width
    function automatic logic signed [49:0] sx50(input logic [DATA_W-1:0] v);
        return $signed({{18{v[DATA_W-1]}}, v});
    endfunction

    // Saturate a 50-bit sum to 32 bits
    function automatic logic [DATA_W-1:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'h8000_0000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

    // Q16.16 product scaling, truncated toward zero
    function automatic logic signed [47:0] qmul(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? 64'sd65535 : 64'sd0);
        return t[63:16];
    endfunction

endpackage

/* hw/rtl/smoothing_spline_band_setup.sv */
// Top level of the cubic smoothing spline band setup block.
// One data point is taken per request. The work on it is set by the single
// bit-serial divider, which runs seven quotients per point, and by the one
// multiplier that forms the six band products in turn; a final point also
// flushes the pending rows, and a row may wait at the output. A quotient with
// a zero divisor ends early, so the first points of a set finish sooner. Up to
// two further points wait in the queue behind the point being worked on. Each
// interior point yields one row, two points late; a final point flushes all
// pending rows. There is no clearing pass after reset.
module smoothing_spline_band_setup #(
    parameter int MAX_DIMS   = ssbs_pkg::DEF_MAX_DIMS,
    parameter int MAX_POINTS = ssbs_pkg::DEF_MAX_POINTS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // abscissa, error_estimate, ordinate_0, ordinate_1, ordinate_2
    input  logic [ssbs_pkg::IN_W-1:0]   s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // row_index, interval_width, qd_lower, qd_diagonal, qd_upper, gram_diagonal,
    // gram_first_upper, gram_second_upper, second_difference_0..2
    output logic [ssbs_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_data
);

    logic [1:0]                  r_dims_val;
    logic                        push, pop, empty, full;
    ssbs_pkg::t_point            f_point, q_point;
    ssbs_pkg::t_div_req          div_req;
    logic                        div_done;
    logic [ssbs_pkg::DATA_W-1:0] div_quot;

    assign o_cfg_ready = 1'b1;

    // Dimension register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims_val <= 2'd1;
        end else if (i_cfg_valid) begin
            r_dims_val <= i_cfg_data;
        end
    end

    ssbs_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_tlast  (s_axis_tlast),
        .i_full   (full),
        .o_push   (push),
        .o_point  (f_point)
    );

    ssbs_queue #(.WIDTH($bits(ssbs_pkg::t_point)), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (f_point),
        .i_pop   (pop),
        .o_data  (q_point),
        .o_empty (empty),
        .o_full  (full)
    );

    ssbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ssbs_back #(.MAX_DIMS(MAX_DIMS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dims     (r_dims_val),
        .i_empty    (empty),
        .i_point    (q_point),
        .o_pop      (pop),
        .o_div_req  (div_req),
        .i_div_done (div_done),
        .i_div_quot (div_quot),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_tdata    (m_axis_tdata),
        .o_tlast    (m_axis_tlast)
    );

endmodule

/* hw/rtl/ssbs_queue.sv */
// Short first-in first-out queue between the front and the back.
module ssbs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_fill;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == CW'(DEPTH));

    // Store the entry at the tail
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Advance the pointers and the fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/ssbs_front.sv */
// Front end: takes points, counts them within a set and marks the final one.
module ssbs_front #(
    parameter int MAX_POINTS = ssbs_pkg::DEF_MAX_POINTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [ssbs_pkg::IN_W-1:0]    i_tdata,
    input  logic                         i_tlast,
    input  logic                         i_full,
    output logic                         o_push,
    output ssbs_pkg::t_point             o_point
);

    localparam int CW = $clog2(MAX_POINTS);

    logic [CW-1:0] r_count;
    logic          fin;

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    // Force the final mark on the last point the index range allows
    assign fin = i_tlast || (r_count == CW'(MAX_POINTS - 1));

    // Classify the point
    always_comb begin
        o_point.x   = i_tdata[31:0];
        o_point.dy  = i_tdata[63:32];
        o_point.y   = i_tdata[159:64];
        o_point.fin = fin;
        o_point.cnt = ssbs_pkg::CNT_W'(r_count);
    end

    // Count points, restart after a final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= fin ? '0 : r_count + 1'b1;
        end
    end

endmodule

/* hw/rtl/ssbs_div.sv */
// Bit-serial signed Q16.16 divider with saturation and zero-divisor handling.
module ssbs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ssbs_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [ssbs_pkg::DATA_W-1:0]   o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [48:0] r_dvd;
    logic [48:0] r_quo;
    logic [31:0] r_dmag;
    logic        r_neg;
    logic [31:0] r_quot;

    logic [32:0] nmag;
    logic [31:0] dmag;
    logic [32:0] rem_sh;
    logic        qbit;
    logic [32:0] rem_nx;
    logic [31:0] sat_q;

    assign o_done = r_done;
    assign o_quot = r_quot;

    // Operand magnitudes
    always_comb begin
        nmag = i_req.num[32] ? (~i_req.num + 33'd1) : i_req.num;
        dmag = i_req.den[31] ? (~i_req.den + 32'd1) : i_req.den;
    end

    // One restoring step
    always_comb begin
        rem_sh = {r_rem, r_dvd[48]};
        qbit   = (rem_sh >= {1'b0, r_dmag});
        rem_nx = qbit ? (rem_sh - {1'b0, r_dmag}) : rem_sh;
    end

    // Saturate and sign the quotient
    always_comb begin
        if (!r_neg) begin
            sat_q = (r_quo > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : r_quo[31:0];
        end else begin
            sat_q = (r_quo > 49'h0_8000_0000) ? 32'h8000_0000 : (~r_quo[31:0] + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_neg  <= i_req.num[32] ^ i_req.den[31];
                r_dmag <= dmag;
                r_rem  <= '0;
                r_dvd  <= {nmag, 16'h0000};
                r_quo  <= '0;
                if (i_req.den == '0) begin
                    // Zero interval: saturate by the dividend's sign, or give zero for a zero dividend
                    r_done <= 1'b1;
                    if (i_req.num == '0) begin
                        r_quot <= '0;
                    end else if (i_req.num[32]) begin
                        r_quot <= 32'h8000_0000;
                    end else begin
                        r_quot <= 32'h7FFF_FFFF;
                    end
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 6'(ssbs_pkg::DIV_ITER);
                end
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_rem <= rem_nx[31:0];
                    r_dvd <= {r_dvd[47:0], 1'b0};
                    r_quo <= {r_quo[47:0], qbit};
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_quot <= sat_q;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

/* hw/rtl/ssbs_back.sv */
// Back end: forms the bands of each row, holds the pending rows and emits them.
module ssbs_back #(
    parameter int MAX_DIMS = ssbs_pkg::DEF_MAX_DIMS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_dims,
    input  logic                          i_empty,
    input  ssbs_pkg::t_point              i_point,
    output logic                          o_pop,
    output ssbs_pkg::t_div_req            o_div_req,
    input  logic                          i_div_done,
    input  logic [ssbs_pkg::DATA_W-1:0]   i_div_quot,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [ssbs_pkg::OUT_W-1:0]    o_tdata,
    output logic                          o_tlast
);

    ssbs_pkg::t_bstate r_state, n_state;

    ssbs_pkg::t_point  r_pt;
    logic [31:0]       r_delx;
    logic [31:0]       r_q [ssbs_pkg::NUM_DIV_OPS];
    logic [2:0]        r_op;
    logic [2:0]        r_mk;
    logic [1:0]        r_ek;
    logic signed [63:0] r_prod;
    logic signed [49:0] r_acc_gd, r_acc_g1, r_acc_g2;
    logic [31:0]       r_px, r_pdy, r_ppdy, r_pdelx;
    logic [31:0]       r_py   [ssbs_pkg::NDIM];
    logic [31:0]       r_prev [ssbs_pkg::NDIM];
    ssbs_pkg::t_row    r_a, r_b, r_nr;
    logic              r_out_valid;
    logic [ssbs_pkg::OUT_W-1:0] r_out_data;
    logic              r_out_last;

    logic [32:0]       ydiff [ssbs_pkg::NDIM];
    logic [31:0]       ma, mb;
    logic signed [47:0] qm;
    logic signed [49:0] qm50;
    ssbs_pkg::t_row    cand;
    logic              cand_last;
    logic              need, out_free, emit_go, adv, emit_end;
    logic [1:0]        dims_eff;
    logic [ssbs_pkg::OUT_W-1:0] pack;

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

    // Ordinate differences against the previous point
    always_comb begin
        for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
            ydiff[d] = {r_pt.y[d][31], r_pt.y[d]} - {r_py[d][31], r_py[d]};
        end
    end

    // Clamp the dimension count
    always_comb begin
        if (i_dims == 2'd0) begin
            dims_eff = 2'd1;
        end else if (int'(i_dims) > MAX_DIMS) begin
            dims_eff = 2'(MAX_DIMS);
        end else begin
            dims_eff = i_dims;
        end
    end

    // Pick the row to emit at this step
    always_comb begin
        unique case (r_ek)
            2'd0: begin
                cand      = r_a;
                cand_last = 1'b0;
            end
            2'd1: begin
                cand      = r_b;
                cand_last = !r_nr.valid;
            end
            default: begin
                cand      = r_nr;
                cand_last = 1'b1;
            end
        endcase
        need     = cand.valid && (r_pt.fin || (r_ek == 2'd0));
        out_free = !r_out_valid || i_tready;
        adv      = !need || out_free;
        emit_end = r_pt.fin ? (r_ek == 2'd2) : (r_ek == 2'd0);
    end

    // Pack the candidate row, blanking unused dimensions
    always_comb begin
        pack[15:0]    = cand.idx;
        pack[47:16]   = cand.w;
        pack[79:48]   = cand.lo;
        pack[111:80]  = cand.dg;
        pack[143:112] = cand.up;
        pack[175:144] = cand.gd;
        pack[207:176] = cand.g1;
        pack[239:208] = cand.g2;
        for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
            pack[240 + 32*d +: 32] = (d < int'(dims_eff)) ? cand.sd[d] : 32'h0;
        end
    end

    // Multiplier operand selection
    always_comb begin
        unique case (r_mk)
            3'd0:    begin ma = r_nr.lo; mb = r_nr.lo; end
            3'd1:    begin ma = r_nr.dg; mb = r_nr.dg; end
            3'd2:    begin ma = r_nr.up; mb = r_nr.up; end
            3'd3:    begin ma = r_b.dg;  mb = r_nr.lo; end
            3'd4:    begin ma = r_b.up;  mb = r_nr.dg; end
            default: begin ma = r_a.up;  mb = r_nr.lo; end
        endcase
        qm   = ssbs_pkg::qmul(r_prod);
        qm50 = {{2{qm[47]}}, qm};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssbs_pkg::ST_IDLE:      if (!i_empty) n_state = ssbs_pkg::ST_DELX;
            ssbs_pkg::ST_DELX:      n_state = ssbs_pkg::ST_DIV_START;
            ssbs_pkg::ST_DIV_START: n_state = ssbs_pkg::ST_DIV_WAIT;
            ssbs_pkg::ST_DIV_WAIT: begin
                if (i_div_done) begin
                    n_state = (r_op == 3'(ssbs_pkg::NUM_DIV_OPS - 1)) ?
                              ssbs_pkg::ST_ROW : ssbs_pkg::ST_DIV_START;
                end
            end
            ssbs_pkg::ST_ROW:       n_state = ssbs_pkg::ST_MUL_A;
            ssbs_pkg::ST_MUL_A:     n_state = ssbs_pkg::ST_MUL_B;
            ssbs_pkg::ST_MUL_B: begin
                n_state = (r_mk == 3'(ssbs_pkg::NUM_MUL_OPS - 1)) ?
                          ssbs_pkg::ST_BANDS : ssbs_pkg::ST_MUL_A;
            end
            ssbs_pkg::ST_BANDS:     n_state = ssbs_pkg::ST_EMIT;
            ssbs_pkg::ST_EMIT:      if (adv && emit_end) n_state = ssbs_pkg::ST_UPDATE;
            default:                n_state = ssbs_pkg::ST_IDLE;
        endcase
    end

    // State outputs: queue pop, divider request, row emission
    always_comb begin
        o_pop           = (r_state == ssbs_pkg::ST_IDLE) && !i_empty;
        emit_go         = (r_state == ssbs_pkg::ST_EMIT) && need && out_free;
        o_div_req.start = (r_state == ssbs_pkg::ST_DIV_START);
        unique case (r_op)
            3'd0:    begin o_div_req.num = {r_ppdy[31], r_ppdy}; o_div_req.den = r_pdelx; end
            3'd1:    begin o_div_req.num = {r_pdy[31], r_pdy};   o_div_req.den = r_delx;  end
            3'd2:    begin o_div_req.num = {r_pdy[31], r_pdy};   o_div_req.den = r_pdelx; end
            3'd3:    begin o_div_req.num = {r_pt.dy[31], r_pt.dy}; o_div_req.den = r_delx; end
            3'd4:    begin o_div_req.num = ydiff[0]; o_div_req.den = r_delx; end
            3'd5:    begin o_div_req.num = ydiff[1]; o_div_req.den = r_delx; end
            3'd6:    begin o_div_req.num = ydiff[2]; o_div_req.den = r_delx; end
            default: begin o_div_req.num = '0;       o_div_req.den = '0;     end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssbs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out_data <= pack;
            r_out_last <= cand_last;
        end
    end

    // Work registers of the current point
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ssbs_pkg::ST_IDLE: begin
                if (o_pop) r_pt <= i_point;
            end
            ssbs_pkg::ST_DELX: begin
                r_delx <= (r_pt.cnt != '0) ?
                          ssbs_pkg::sat32(ssbs_pkg::sx50(r_pt.x) - ssbs_pkg::sx50(r_px)) : '0;
                r_op   <= '0;
            end
            ssbs_pkg::ST_DIV_WAIT: begin
                if (i_div_done) begin
                    r_q[r_op] <= i_div_quot;
                    r_op      <= r_op + 1'b1;
                end
            end
            ssbs_pkg::ST_ROW: begin
                r_mk     <= '0;
                r_acc_gd <= '0;
                r_acc_g1 <= '0;
                r_acc_g2 <= '0;
            end
            ssbs_pkg::ST_MUL_A: begin
                r_prod <= $signed(ma) * $signed(mb);
            end
            ssbs_pkg::ST_MUL_B: begin
                if (r_mk <= 3'd2) begin
                    r_acc_gd <= r_acc_gd + qm50;
                end else if (r_mk <= 3'd4) begin
                    r_acc_g1 <= r_acc_g1 + qm50;
                end else begin
                    r_acc_g2 <= r_acc_g2 + qm50;
                end
                r_mk <= r_mk + 1'b1;
            end
            ssbs_pkg::ST_BANDS: begin
                r_ek <= '0;
            end
            ssbs_pkg::ST_EMIT: begin
                if (adv && !emit_end) r_ek <= r_ek + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Set state: previous point, pending rows and slopes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px    <= '0;
            r_pdy   <= '0;
            r_ppdy  <= '0;
            r_pdelx <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_nr    <= '0;
            for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
                r_py[d]   <= '0;
                r_prev[d] <= '0;
            end
        end else begin
            unique case (r_state)
                ssbs_pkg::ST_ROW: begin
                    r_nr.valid <= (r_pt.cnt > 16'd1);
                    r_nr.idx   <= r_pt.cnt - 1'b1;
                    r_nr.w     <= r_delx;
                    r_nr.lo    <= r_q[0];
                    r_nr.dg    <= ssbs_pkg::sat32(-ssbs_pkg::sx50(r_q[1]) -
                                                   ssbs_pkg::sx50(r_q[2]));
                    r_nr.up    <= r_q[3];
                    r_nr.gd    <= '0;
                    r_nr.g1    <= '0;
                    r_nr.g2    <= '0;
                    for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
                        r_nr.sd[d] <= (r_pt.cnt > 16'd1) ?
                            ssbs_pkg::sat32(ssbs_pkg::sx50(r_q[4+d]) -
                                            ssbs_pkg::sx50(r_prev[d])) : '0;
                    end
                end
                ssbs_pkg::ST_BANDS: begin
                    r_nr.gd <= ssbs_pkg::sat32(r_acc_gd);
                    if (r_b.valid) r_b.g1 <= ssbs_pkg::sat32(r_acc_g1);
                    if (r_a.valid) r_a.g2 <= ssbs_pkg::sat32(r_acc_g2);
                    if (r_pt.cnt != '0) begin
                        for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
                            r_prev[d] <= r_q[4+d];
                        end
                    end
                end
                ssbs_pkg::ST_UPDATE: begin
                    if (r_pt.fin) begin
                        // Drop the whole set
                        r_px    <= '0;
                        r_pdy   <= '0;
                        r_ppdy  <= '0;
                        r_pdelx <= '0;
                        r_a     <= '0;
                        r_b     <= '0;
                        r_nr    <= '0;
                        for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
                            r_py[d]   <= '0;
                            r_prev[d] <= '0;
                        end
                    end else begin
                        // Advance the window by one point
                        r_a     <= r_b;
                        r_b     <= r_nr;
                        r_ppdy  <= r_pdy;
                        r_pdy   <= r_pt.dy;
                        r_px    <= r_pt.x;
                        r_pdelx <= r_delx;
                        for (int d = 0; d < ssbs_pkg::NDIM; d++) begin
                            r_py[d] <= r_pt.y[d];
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ssbs_checker.sv */
// Port-level checks on the band setup block, bound to its top level.
module ssbs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [ssbs_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                       m_axis_tlast
);

    // Hold a result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // No result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result shown after reset");

    // Interior rows never describe the first point
    a_row_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'd0)
        else $error("row index zero");

    // The final row has no superdiagonals
    a_last_bands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[207:176] == 32'd0 && m_axis_tdata[239:208] == 32'd0)
        else $error("superdiagonal on final row");

endmodule

bind smoothing_spline_band_setup ssbs_checker u_ssbs_checker (.*);
